// ===== hdl/cpp_pkg.sv =====
// Shared types and constants for the codec packet parser.
// No dependencies; every other file refers to this package by scoped names.
package cpp_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC   = 4'd0,
      PH_PROFILE = 4'd1,
      PH_EPOCH   = 4'd2,
      PH_INDEX   = 4'd3,
      PH_TIME    = 4'd4,
      PH_FLAGS   = 4'd5,
      PH_SAMPLES = 4'd6,
      PH_PAYSIZE = 4'd7,
      PH_PAYLOAD = 4'd8,
      PH_TAIL    = 4'd9,
      PH_HALT    = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TRUNC   = 2'd1,
      ST_PROTO   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   localparam logic       KIND_CODE   = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;
   localparam logic [4:0] CB_RESET    = 5'd8;
   localparam logic [12:0] COUNT_MAX  = 13'd8191;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [9:0]  code_value;
      logic [1:0]  frame_number;
      logic [3:0]  book_number;
      logic [1:0]  status;
      logic [63:0] epoch_value;
      logic [63:0] packet_index;
      logic [63:0] timestamp_ms;
      logic [2:0]  flag_bits;
      logic [9:0]  sample_count;
      logic        last;
   } rsp_payload_type;

   // Which results one request produced.
   typedef struct packed {
      logic code_hit;
      logic status_hit;
   } result_flags_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0: b = 8'h4B;
         2'd1: b = 8'h4D;
         2'd2: b = 8'h41;
         default: b = 8'h02;
      endcase
      return b;
   endfunction

   function automatic logic books_valid(input logic [4:0] cb);
      return (cb == 5'd4) || (cb == 5'd8) || (cb == 5'd16);
   endfunction

endpackage

// ===== hdl/codec_packet_parser_unit.sv =====
// Top level of the codec packet parser: codebook register, parser, result buffer.
// Depends on cpp_pkg, cpp_parse and cpp_obuf.
//
//   channel  ports                         moves
//   req      req_valid/ready/payload       one packet byte and its last mark
//   rsp      rsp_valid/ready/payload       code token or final packet status
//   csr      csr_valid/ready/data          codebooks per frame (5 bits)
//
// One byte is accepted per cycle while req_ready is high; its first result appears in the next cycle.
// A byte that completes a code and ends the packet yields two results; the
// second waits in the overflow slot until it moves to the output register,
// holding off req_ready until it has moved there. Reset is synchronous; the
// codebook count resets to 8.
// A stalled rsp holds its result; a new byte is still taken if it drains.
module codec_packet_parser_unit #(
   parameter int MAX_PACKET_BYTES = 256,
   parameter int RESET_FLAG_BIT   = 1,
   parameter int DISCONT_FLAG_BIT = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cpp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cpp_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [4:0]               csr_data
);

   logic [4:0]                cb_ff;
   logic                      req_fire;
   cpp_pkg::result_flags_type res_flags;
   cpp_pkg::rsp_payload_type  code_res;
   cpp_pkg::rsp_payload_type  status_res;

   assign csr_ready = 1'b1;
   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff <= cpp_pkg::CB_RESET;
      end else if (csr_valid && csr_ready) begin
         cb_ff <= csr_data;
      end
   end

   cpp_parse #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
      .RESET_FLAG_BIT(RESET_FLAG_BIT),
      .DISCONT_FLAG_BIT(DISCONT_FLAG_BIT)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .accept(req_fire),
      .req_payload(req_payload),
      .codebook(cb_ff),
      .res_flags(res_flags),
      .code_res(code_res),
      .status_res(status_res)
   );

   cpp_obuf u_obuf (
      .clock(clock),
      .reset(reset),
      .req_fire(req_fire),
      .res_flags(res_flags),
      .code_res(code_res),
      .status_res(status_res),
      .in_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== hdl/cpp_parse.sv =====
// Per-byte packet parser: header varints, checks, code unpacking and status.
// Depends on cpp_pkg.
module cpp_parse #(
   parameter int MAX_PACKET_BYTES = 256,
   parameter int RESET_FLAG_BIT   = 1,
   parameter int DISCONT_FLAG_BIT = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  cpp_pkg::req_payload_type req_payload,
   input  logic [4:0]               codebook,
   output cpp_pkg::result_flags_type res_flags,
   output cpp_pkg::rsp_payload_type code_res,
   output cpp_pkg::rsp_payload_type status_res
);

   cpp_pkg::phase_type phase_ff, phase_in;
   logic [12:0] count_ff, count_in;
   logic        magic_ok_ff, magic_ok_in;
   logic        err_ff, err_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  slot_ff, slot_in;
   logic        profile_ok_ff, profile_ok_in;
   logic [63:0] epoch_ff, epoch_in;
   logic [63:0] index_ff, index_in;
   logic [63:0] time_ff, time_in;
   logic [7:0]  flags_ff, flags_in;
   logic [9:0]  samples_ff, samples_in;
   logic [1:0]  frames_ff, frames_in;
   logic [6:0]  left_ff, left_in;
   logic [15:0] buf_ff, buf_in;
   logic [4:0]  fill_ff, fill_in;
   logic [1:0]  frame_ff, frame_in;
   logic [3:0]  book_ff, book_in;

   logic               code_hit;
   logic [9:0]         code_val;
   logic [1:0]         code_frame;
   logic [3:0]         code_book;
   cpp_pkg::status_type st_val;
   logic [63:0]        hdr_epoch, hdr_index, hdr_time;
   logic [7:0]         hdr_flags;
   logic [9:0]         hdr_samples;

   always_comb begin
      logic [7:0]  octet;
      logic [6:0]  shamt;
      logic [70:0] wide;
      logic [63:0] v;
      logic [6:0]  fb;
      logic [10:0] nbits;
      logic [10:0] expb;
      logic        hdr_ok;
      logic [2:0]  sh;
      logic [15:0] mask;
      octet = req_payload.data_byte;
      shamt = 7'({3'b0, slot_ff} * 7'd7);
      wide  = {64'b0, octet[6:0]} << shamt;
      v     = acc_ff | wide[63:0];
      fb    = 7'(frames_ff) * 7'(codebook);
      nbits = 11'(fb) * 11'd10;
      expb  = (nbits + 11'd7) >> 3;
      hdr_ok = cpp_pkg::books_valid(codebook) && profile_ok_ff && (frames_ff != 2'd0)
         && (flags_ff[7:3] == 5'd0)
         && !(flags_ff[DISCONT_FLAG_BIT] && !flags_ff[RESET_FLAG_BIT])
         && !(flags_ff[RESET_FLAG_BIT] && (index_ff != 64'd0));
      sh   = 3'd0;
      mask = 16'd0;

      phase_in = phase_ff;
      count_in = count_ff;
      magic_ok_in = magic_ok_ff;
      err_in = err_ff;
      acc_in = acc_ff;
      slot_in = slot_ff;
      profile_ok_in = profile_ok_ff;
      epoch_in = epoch_ff;
      index_in = index_ff;
      time_in = time_ff;
      flags_in = flags_ff;
      samples_in = samples_ff;
      frames_in = frames_ff;
      left_in = left_ff;
      buf_in = buf_ff;
      fill_in = fill_ff;
      frame_in = frame_ff;
      book_in = book_ff;
      code_hit = 1'b0;
      code_val = 10'd0;
      code_frame = frame_ff;
      code_book = book_ff;
      st_val = cpp_pkg::ST_OK;
      hdr_epoch = 64'd0;
      hdr_index = 64'd0;
      hdr_time = 64'd0;
      hdr_flags = 8'd0;
      hdr_samples = 10'd0;

      if (accept) begin
         if (count_ff != cpp_pkg::COUNT_MAX) begin
            count_in = count_ff + 13'd1;
         end
         unique case (phase_ff)
            cpp_pkg::PH_MAGIC: begin
               if (octet != cpp_pkg::magic_byte(count_ff[1:0])) begin
                  magic_ok_in = 1'b0;
                  phase_in = cpp_pkg::PH_HALT;
               end else if (count_ff >= 13'd3) begin
                  phase_in = cpp_pkg::PH_PROFILE;
               end
            end
            cpp_pkg::PH_FLAGS: begin
               flags_in = octet;
               phase_in = cpp_pkg::PH_SAMPLES;
            end
            cpp_pkg::PH_PROFILE, cpp_pkg::PH_EPOCH, cpp_pkg::PH_INDEX,
            cpp_pkg::PH_TIME, cpp_pkg::PH_SAMPLES, cpp_pkg::PH_PAYSIZE: begin
               if ((slot_ff == 4'd9) && (octet[7:1] != 7'd0)) begin
                  err_in = 1'b1;
                  phase_in = cpp_pkg::PH_HALT;
               end else if (octet[7]) begin
                  acc_in = v;
                  slot_in = slot_ff + 4'd1;
               end else if ((slot_ff != 4'd0) && (octet == 8'd0)) begin
                  err_in = 1'b1;
                  phase_in = cpp_pkg::PH_HALT;
               end else begin
                  acc_in = 64'd0;
                  slot_in = 4'd0;
                  unique case (phase_ff)
                     cpp_pkg::PH_PROFILE: begin
                        profile_ok_in = (v == 64'd1);
                        phase_in = cpp_pkg::PH_EPOCH;
                     end
                     cpp_pkg::PH_EPOCH: begin
                        epoch_in = v;
                        phase_in = cpp_pkg::PH_INDEX;
                     end
                     cpp_pkg::PH_INDEX: begin
                        index_in = v;
                        phase_in = cpp_pkg::PH_TIME;
                     end
                     cpp_pkg::PH_TIME: begin
                        time_in = v;
                        phase_in = cpp_pkg::PH_FLAGS;
                     end
                     cpp_pkg::PH_SAMPLES: begin
                        samples_in = v[9:0];
                        if (v == 64'd320) frames_in = 2'd1;
                        else if (v == 64'd640) frames_in = 2'd2;
                        else if (v == 64'd960) frames_in = 2'd3;
                        else frames_in = 2'd0;
                        phase_in = cpp_pkg::PH_PAYSIZE;
                     end
                     default: begin
                        // Payload size closes the header.
                        if (!hdr_ok || (v != 64'(expb))) begin
                           err_in = 1'b1;
                           phase_in = cpp_pkg::PH_HALT;
                        end else begin
                           left_in = expb[6:0];
                           buf_in = 16'd0;
                           fill_in = 5'd0;
                           frame_in = 2'd0;
                           book_in = 4'd0;
                           phase_in = cpp_pkg::PH_PAYLOAD;
                        end
                     end
                  endcase
               end
            end
            cpp_pkg::PH_PAYLOAD: begin
               buf_in = {buf_ff[7:0], octet};
               fill_in = fill_ff + 5'd8;
               if (fill_in >= 5'd10) begin
                  sh = 3'(fill_in - 5'd10);
                  code_val = 10'(buf_in >> sh);
                  code_hit = 1'b1;
                  fill_in = fill_in - 5'd10;
                  if ((book_ff == 4'd15) || (({1'b0, book_ff} + 5'd1) >= codebook)) begin
                     book_in = 4'd0;
                     frame_in = frame_ff + 2'd1;
                  end else begin
                     book_in = book_ff + 4'd1;
                  end
               end
               if (left_ff != 7'd0) begin
                  left_in = left_ff - 7'd1;
               end
               if (left_in == 7'd0) begin
                  mask = (16'd1 << fill_in[2:0]) - 16'd1;
                  if ((buf_in & mask) != 16'd0) begin
                     err_in = 1'b1;
                     phase_in = cpp_pkg::PH_HALT;
                  end else begin
                     phase_in = cpp_pkg::PH_TAIL;
                  end
               end
            end
            cpp_pkg::PH_TAIL: begin
               err_in = 1'b1;
               phase_in = cpp_pkg::PH_HALT;
            end
            default: begin
            end
         endcase

         if (req_payload.last_byte) begin
            priority if (!cpp_pkg::books_valid(codebook)) st_val = cpp_pkg::ST_INVALID;
            else if (count_in < 13'd4) st_val = cpp_pkg::ST_TRUNC;
            else if (count_in > 13'(MAX_PACKET_BYTES)) st_val = cpp_pkg::ST_PROTO;
            else if (!magic_ok_in) st_val = cpp_pkg::ST_PROTO;
            else if (err_in) st_val = cpp_pkg::ST_PROTO;
            else if (phase_in != cpp_pkg::PH_TAIL) st_val = cpp_pkg::ST_TRUNC;
            else st_val = cpp_pkg::ST_OK;
            if (st_val == cpp_pkg::ST_OK) begin
               hdr_epoch = epoch_in;
               hdr_index = index_in;
               hdr_time = time_in;
               hdr_flags = flags_in;
               hdr_samples = samples_in;
            end
            // Everything per packet returns to its reset value.
            phase_in = cpp_pkg::PH_MAGIC;
            count_in = 13'd0;
            magic_ok_in = 1'b1;
            err_in = 1'b0;
            acc_in = 64'd0;
            slot_in = 4'd0;
            profile_ok_in = 1'b0;
            epoch_in = 64'd0;
            index_in = 64'd0;
            time_in = 64'd0;
            flags_in = 8'd0;
            samples_in = 10'd0;
            frames_in = 2'd0;
            left_in = 7'd0;
            buf_in = 16'd0;
            fill_in = 5'd0;
            frame_in = 2'd0;
            book_in = 4'd0;
         end
      end
   end

   always_comb begin
      res_flags.code_hit = code_hit;
      res_flags.status_hit = accept && req_payload.last_byte;

      code_res = '0;
      code_res.kind = cpp_pkg::KIND_CODE;
      code_res.code_value = code_val;
      code_res.frame_number = code_frame;
      code_res.book_number = code_book;

      status_res = '0;
      status_res.kind = cpp_pkg::KIND_STATUS;
      status_res.status = st_val;
      status_res.epoch_value = hdr_epoch;
      status_res.packet_index = hdr_index;
      status_res.timestamp_ms = hdr_time;
      status_res.flag_bits = hdr_flags[2:0];
      status_res.sample_count = hdr_samples;
      status_res.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cpp_pkg::PH_MAGIC;
         count_ff <= 13'd0;
         magic_ok_ff <= 1'b1;
         err_ff <= 1'b0;
         acc_ff <= 64'd0;
         slot_ff <= 4'd0;
         profile_ok_ff <= 1'b0;
         epoch_ff <= 64'd0;
         index_ff <= 64'd0;
         time_ff <= 64'd0;
         flags_ff <= 8'd0;
         samples_ff <= 10'd0;
         frames_ff <= 2'd0;
         left_ff <= 7'd0;
         buf_ff <= 16'd0;
         fill_ff <= 5'd0;
         frame_ff <= 2'd0;
         book_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         magic_ok_ff <= magic_ok_in;
         err_ff <= err_in;
         acc_ff <= acc_in;
         slot_ff <= slot_in;
         profile_ok_ff <= profile_ok_in;
         epoch_ff <= epoch_in;
         index_ff <= index_in;
         time_ff <= time_in;
         flags_ff <= flags_in;
         samples_ff <= samples_in;
         frames_ff <= frames_in;
         left_ff <= left_in;
         buf_ff <= buf_in;
         fill_ff <= fill_in;
         frame_ff <= frame_in;
         book_ff <= book_in;
      end
   end

endmodule

// ===== hdl/cpp_obuf.sv =====
// Result register with one overflow slot, so a request can yield two results.
// Depends on cpp_pkg.
module cpp_obuf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  cpp_pkg::result_flags_type res_flags,
   input  cpp_pkg::rsp_payload_type  code_res,
   input  cpp_pkg::rsp_payload_type  status_res,
   output logic                      in_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cpp_pkg::rsp_payload_type  rsp_payload
);

   logic                     out_valid_ff;
   cpp_pkg::rsp_payload_type out_ff;
   logic                     hold_valid_ff;
   cpp_pkg::rsp_payload_type hold_ff;

   // New requests wait while a second result is still parked.
   assign in_ready = !hold_valid_ff && (!out_valid_ff || rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            out_valid_ff <= res_flags.code_hit || res_flags.status_hit;
            hold_valid_ff <= res_flags.code_hit && res_flags.status_hit;
         end else if (hold_valid_ff && (!out_valid_ff || rsp_ready)) begin
            out_valid_ff <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_ff <= res_flags.code_hit ? code_res : status_res;
         hold_ff <= status_res;
      end else if (hold_valid_ff && (!out_valid_ff || rsp_ready)) begin
         out_ff <= hold_ff;
      end
   end

endmodule

// ===== hdl/cpp_checker.sv =====
// Port-level checks for codec_packet_parser_unit, attached by bind.
// Depends on cpp_pkg.
module cpp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input cpp_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input cpp_pkg::rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp result changed while stalled");

   a_code_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == cpp_pkg::KIND_CODE)
      |-> !rsp_payload.last && (rsp_payload.status == cpp_pkg::ST_OK))
      else $error("code result carries status or last");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == cpp_pkg::KIND_STATUS) |-> rsp_payload.last)
      else $error("status result without last");

   a_bad_status_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == cpp_pkg::KIND_STATUS)
      && (rsp_payload.status != cpp_pkg::ST_OK)
      |-> (rsp_payload.epoch_value == 64'd0) && (rsp_payload.sample_count == 10'd0))
      else $error("failed packet reports header fields");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_byte |=> rsp_valid)
      else $error("final byte produced no result");

endmodule

bind codec_packet_parser_unit cpp_checker u_cpp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_payload(req_payload),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);
